FILE: design/pdw_pkg.sv
// Package for the PRP list walker: payload structs, result codes and widths.
// No dependencies; every other design file imports it.
package pdw_pkg;

  localparam int unsigned LEN_W   = 21;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [1:0] KIND_SEGMENT = 2'd0;
  localparam logic [1:0] KIND_FETCH   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic [CNT_W-1:0] FETCH_BYTES = 13'd8;

  localparam logic [LEN_W-1:0] MAX_XFER_RST = 21'd32768;
  localparam logic [IDX_W-1:0] MAX_LIST_RST = 10'd64;

  localparam logic REG_MAX_XFER = 1'b0;
  localparam logic REG_MAX_LIST = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] first_pointer;
    logic [ADDR_W-1:0] second_pointer;
    logic [LEN_W-1:0]  byte_length;
    logic              to_host;
    logic [ADDR_W-1:0] list_entry;
  } pdw_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  byte_count;
    logic              direction;
    logic [1:0]        status;
    logic              finished;
  } pdw_out_t;

  typedef struct packed {
    logic [1:0] cnt;
    pdw_out_t   r0;
    pdw_out_t   r1;
  } pdw_pair_t;

  typedef struct packed {
    logic       rdy;
    logic [1:0] cnt;
  } pdw_buf_sts_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_transfer_bytes;
    logic [IDX_W-1:0] max_list_entries;
  } pdw_cfg_t;

endpackage

FILE: design/pdw_cfg_regs.sv
// APB configuration registers of the PRP list walker.
// Depends on pdw_pkg.
module pdw_cfg_regs import pdw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready,
  output pdw_cfg_t           cfg
);

  logic [LEN_W-1:0] max_xfer_r;
  logic [IDX_W-1:0] max_list_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_xfer_r <= MAX_XFER_RST;
      max_list_r <= MAX_LIST_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_MAX_XFER) begin
        max_xfer_r <= pwdata[LEN_W-1:0];
      end else begin
        max_list_r <= pwdata[IDX_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_XFER) begin
      prdata = APB_W'(max_xfer_r);
    end else begin
      prdata = APB_W'(max_list_r);
    end
  end

  assign cfg.max_transfer_bytes = max_xfer_r;
  assign cfg.max_list_entries   = max_list_r;

endmodule

FILE: design/pdw_walk_core.sv
// Input register, walk state and per-transaction result logic of the PRP list walker.
// Depends on pdw_pkg; hands up to two results per transaction to pdw_result_buf.
module pdw_walk_core import pdw_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  pdw_in_t      in_data,
  input  pdw_cfg_t     cfg,
  input  pdw_buf_sts_t buf_sts,
  output logic         pair_vld,
  output pdw_pair_t    pair
);

  localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);
  localparam logic [LEN_W:0] PAGE_W = (LEN_W+1)'(PAGE_BYTES);

  logic              in_vld_r;
  pdw_in_t           in_r;
  logic              take;

  logic              awaiting_r, awaiting_nxt;
  logic [ADDR_W-1:0] list_base_r, list_base_nxt;
  logic [IDX_W-1:0]  entry_index_r, entry_index_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic              held_dir_r, held_dir_nxt;

  logic [LEN_W:0]    len;
  logic [LEN_W:0]    chunk;
  logic [LEN_W:0]    rem;
  logic [LEN_W:0]    left_n;
  logic [IDX_W:0]    next_idx;
  logic              start_bad;
  logic              entry_bad;
  pdw_pair_t         pr;

  assign take     = in_vld_r & buf_sts.rdy;
  assign in_stall = in_vld_r & ~buf_sts.rdy;
  assign pair_vld = take;
  assign pair     = pr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r    <= 1'b0;
      list_base_r   <= '0;
      entry_index_r <= '0;
      bytes_left_r  <= '0;
      held_dir_r    <= 1'b0;
    end else if (take) begin
      awaiting_r    <= awaiting_nxt;
      list_base_r   <= list_base_nxt;
      entry_index_r <= entry_index_nxt;
      bytes_left_r  <= bytes_left_nxt;
      held_dir_r    <= held_dir_nxt;
    end
  end

  always_comb begin
    awaiting_nxt    = awaiting_r;
    list_base_nxt   = list_base_r;
    entry_index_nxt = entry_index_r;
    bytes_left_nxt  = bytes_left_r;
    held_dir_nxt    = held_dir_r;
    pr              = '0;
    len             = {1'b0, in_r.byte_length};
    chunk           = '0;
    rem             = '0;
    left_n          = '0;
    next_idx        = '0;
    start_bad       = 1'b0;
    entry_bad       = 1'b0;

    if (in_r.mode == 1'b0) begin
      awaiting_nxt = 1'b0;
      start_bad = (len == '0) || (in_r.byte_length > cfg.max_transfer_bytes) ||
                  (in_r.first_pointer == '0) ||
                  ((len > PAGE_W) && (in_r.second_pointer == '0));
      chunk = PAGE_W - (LEN_W+1)'(in_r.first_pointer[PAGE_BITS-1:0]);
      if (chunk > len) begin
        chunk = len;
      end
      rem = len - chunk;
      pr.r0.direction = in_r.to_host;
      pr.r1.direction = in_r.to_host;
      if (start_bad) begin
        pr.cnt         = 2'd1;
        pr.r0.kind     = KIND_ERROR;
        pr.r0.status   = ST_INVALID;
        pr.r0.finished = 1'b1;
      end else begin
        pr.r0.kind       = KIND_SEGMENT;
        pr.r0.address    = in_r.first_pointer;
        pr.r0.byte_count = chunk[CNT_W-1:0];
        pr.r0.status     = ST_OK;
        pr.r0.finished   = (rem == '0);
        if (rem == '0) begin
          pr.cnt = 2'd1;
        end else begin
          pr.cnt = 2'd2;
          if (rem <= PAGE_W) begin
            pr.r1.kind       = KIND_SEGMENT;
            pr.r1.address    = in_r.second_pointer;
            pr.r1.byte_count = rem[CNT_W-1:0];
            pr.r1.status     = ST_OK;
            pr.r1.finished   = 1'b1;
          end else if (in_r.second_pointer[PAGE_BITS-1:0] != '0) begin
            pr.r1.kind     = KIND_ERROR;
            pr.r1.status   = ST_INVALID;
            pr.r1.finished = 1'b1;
          end else begin
            awaiting_nxt     = 1'b1;
            list_base_nxt    = in_r.second_pointer;
            entry_index_nxt  = '0;
            bytes_left_nxt   = rem[LEN_W-1:0];
            held_dir_nxt     = in_r.to_host;
            pr.r1.kind       = KIND_FETCH;
            pr.r1.address    = in_r.second_pointer;
            pr.r1.byte_count = FETCH_BYTES;
            pr.r1.status     = ST_OK;
          end
        end
      end
    end else if (awaiting_r) begin
      pr.r0.direction = held_dir_r;
      pr.r1.direction = held_dir_r;
      entry_bad = (in_r.list_entry == '0) || (in_r.list_entry[PAGE_BITS-1:0] != '0);
      chunk = {1'b0, bytes_left_r};
      if (chunk > PAGE_W) begin
        chunk = PAGE_W;
      end
      left_n   = {1'b0, bytes_left_r} - chunk;
      next_idx = {1'b0, entry_index_r} + (IDX_W+1)'(1);
      if (entry_bad) begin
        awaiting_nxt   = 1'b0;
        pr.cnt         = 2'd1;
        pr.r0.kind     = KIND_ERROR;
        pr.r0.status   = ST_INVALID;
        pr.r0.finished = 1'b1;
      end else begin
        bytes_left_nxt   = left_n[LEN_W-1:0];
        pr.r0.kind       = KIND_SEGMENT;
        pr.r0.address    = in_r.list_entry;
        pr.r0.byte_count = chunk[CNT_W-1:0];
        pr.r0.status     = ST_OK;
        pr.r0.finished   = (left_n == '0);
        if (left_n == '0) begin
          awaiting_nxt = 1'b0;
          pr.cnt       = 2'd1;
        end else if (next_idx >= {1'b0, cfg.max_list_entries}) begin
          awaiting_nxt   = 1'b0;
          pr.cnt         = 2'd2;
          pr.r1.kind     = KIND_ERROR;
          pr.r1.status   = ST_TOO_LONG;
          pr.r1.finished = 1'b1;
        end else begin
          entry_index_nxt  = next_idx[IDX_W-1:0];
          pr.cnt           = 2'd2;
          pr.r1.kind       = KIND_FETCH;
          pr.r1.address    = list_base_r + ADDR_W'({next_idx[IDX_W-1:0], 3'b000});
          pr.r1.byte_count = FETCH_BYTES;
          pr.r1.status     = ST_OK;
        end
      end
    end
  end

endmodule

FILE: design/pdw_result_buf.sv
// Two-entry result register of the PRP list walker; drains one result per cycle
// while out_stall is low. Depends on pdw_pkg; fed by pdw_walk_core.
module pdw_result_buf import pdw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         pair_vld,
  input  pdw_pair_t    pair,
  output pdw_buf_sts_t sts,
  output logic         out_valid,
  input  logic         out_stall,
  output pdw_out_t     out_data
);

  logic [1:0] cnt_r;
  pdw_out_t   slot0_r;
  pdw_out_t   slot1_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign pop       = out_valid & ~out_stall;
  assign sts.cnt   = cnt_r;
  assign sts.rdy   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (pair_vld) begin
      cnt_r <= pair.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_vld) begin
      slot0_r <= pair.r0;
      slot1_r <= pair.r1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

FILE: design/prp_list_dma_walker.sv
// PRP list walker top level: an input transaction waits in the input register until the result
// buffer is ready, then moves into the result register. Throughput: one input transaction per
// cycle when it yields one result and out_stall is low; one with two results stalls the input
// until the first drains, as the single-port result drain (one result per unstalled cycle) sets
// it. Reset (rst_n low, synchronous) empties both stages, clears the walk state and loads the
// register defaults 32768 and 64. Depends on pdw_pkg, pdw_cfg_regs, pdw_walk_core, pdw_result_buf.
module prp_list_dma_walker import pdw_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pdw_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pdw_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  pdw_cfg_t     cfg;
  pdw_buf_sts_t buf_sts;
  pdw_pair_t    pair;
  logic         pair_vld;

  pdw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdw_walk_core #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .buf_sts  (buf_sts),
    .pair_vld (pair_vld),
    .pair     (pair)
  );

  pdw_result_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair_vld  (pair_vld),
    .pair      (pair),
    .sts       (buf_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_buf_depth: assert property (@(posedge clk) disable iff (!rst_n)
    buf_sts.cnt != 2'd3)
    else $error("result buffer count out of range");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (buf_sts.cnt != 2'd0))
    else $error("input stalled with empty result buffer");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_ERROR) |->
      (out_data.address == '0 && out_data.byte_count == '0 && out_data.finished))
    else $error("malformed error result");

  a_fetch_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_FETCH) |->
      (out_data.byte_count == FETCH_BYTES && !out_data.finished &&
       out_data.status == ST_OK))
    else $error("malformed fetch result");

endmodule

FILE: dv/prp_list_dma_walker_tb.sv
// Self-checking testbench for prp_list_dma_walker: random and directed transfer starts
// and list entries, with a scoreboard class that predicts every segment, fetch and error.
// Depends on pdw_pkg and the prp_list_dma_walker RTL.
import pdw_pkg::*;

localparam int unsigned WALK_PAGE = 4096;

class prp_walk_board;
  int unsigned max_xfer;
  int unsigned max_list;
  bit          awaiting;
  logic [63:0] list_base;
  int unsigned entry_idx;
  int unsigned bytes_left;
  logic        held_dir;
  pdw_out_t    pending_results[$];
  int unsigned errors;
  int unsigned accepted;
  int unsigned checked;
  int unsigned n_seg;
  int unsigned n_fetch;
  int unsigned n_err;

  function new();
    max_xfer   = 32768;
    max_list   = 64;
    awaiting   = 1'b0;
    list_base  = '0;
    entry_idx  = 0;
    bytes_left = 0;
    held_dir   = 1'b0;
    errors     = 0;
    accepted   = 0;
    checked    = 0;
    n_seg      = 0;
    n_fetch    = 0;
    n_err      = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void set_reg(logic sel, int unsigned value);
    if (sel == REG_MAX_XFER) begin
      max_xfer = value & 32'h1F_FFFF;
    end else begin
      max_list = value & 32'h3FF;
    end
  endfunction

  function void check_reg(logic sel, logic [APB_W-1:0] rd);
    int unsigned want;
    want = (sel == REG_MAX_XFER) ? max_xfer : max_list;
    if (rd !== want) begin
      $display("%0t register %0d readback: expected %0d, actual %0d", $time, sel, want, rd);
      errors++;
    end
  endfunction

  function void push(logic [1:0] k, logic [63:0] a, int unsigned c, logic d,
                     logic [1:0] s, logic f);
    pdw_out_t r;
    r.kind       = k;
    r.address    = a;
    r.byte_count = c[CNT_W-1:0];
    r.direction  = d;
    r.status     = s;
    r.finished   = f;
    pending_results.push_back(r);
  endfunction

  // Predict the results of one accepted transaction and advance the walk state.
  function void note_request(pdw_in_t it);
    logic [63:0] mask;
    int unsigned len;
    int unsigned chunk;
    int unsigned rem;
    int unsigned nxt;
    mask = 64'(WALK_PAGE - 1);
    accepted++;
    if (it.mode == 1'b0) begin
      awaiting = 1'b0;
      len = 32'(it.byte_length);
      if (len == 0 || len > max_xfer || it.first_pointer == 0 ||
          (len > WALK_PAGE && it.second_pointer == 0)) begin
        push(KIND_ERROR, '0, 0, it.to_host, ST_INVALID, 1'b1);
        return;
      end
      chunk = WALK_PAGE - 32'(it.first_pointer & mask);
      if (chunk > len) chunk = len;
      rem = len - chunk;
      push(KIND_SEGMENT, it.first_pointer, chunk, it.to_host, ST_OK, rem == 0);
      if (rem == 0) return;
      if (rem <= WALK_PAGE) begin
        push(KIND_SEGMENT, it.second_pointer, rem, it.to_host, ST_OK, 1'b1);
        return;
      end
      if ((it.second_pointer & mask) != 0) begin
        push(KIND_ERROR, '0, 0, it.to_host, ST_INVALID, 1'b1);
        return;
      end
      awaiting   = 1'b1;
      list_base  = it.second_pointer;
      entry_idx  = 0;
      bytes_left = rem;
      held_dir   = it.to_host;
      push(KIND_FETCH, list_base, 32'(FETCH_BYTES), held_dir, ST_OK, 1'b0);
    end else begin
      if (!awaiting) return;
      if (it.list_entry == 0 || (it.list_entry & mask) != 0) begin
        awaiting = 1'b0;
        push(KIND_ERROR, '0, 0, held_dir, ST_INVALID, 1'b1);
        return;
      end
      chunk = (bytes_left > WALK_PAGE) ? WALK_PAGE : bytes_left;
      bytes_left = bytes_left - chunk;
      push(KIND_SEGMENT, it.list_entry, chunk, held_dir, ST_OK, bytes_left == 0);
      if (bytes_left == 0) begin
        awaiting = 1'b0;
        return;
      end
      nxt = entry_idx + 1;
      if (nxt >= max_list) begin
        awaiting = 1'b0;
        push(KIND_ERROR, '0, 0, held_dir, ST_TOO_LONG, 1'b1);
        return;
      end
      entry_idx = nxt & 32'h3FF;
      push(KIND_FETCH, list_base + 64'(entry_idx) * 64'd8, 32'(FETCH_BYTES), held_dir,
           ST_OK, 1'b0);
    end
  endfunction

  function void cmp_field(string fname, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t result %0d field %s: expected %0h, actual %0h", $time, checked, fname,
               e, a);
      errors++;
    end
  endfunction

  function void check_result(pdw_out_t got);
    pdw_out_t e;
    if (pending_results.size() == 0) begin
      $display("%0t unexpected result: expected none, actual %0h", $time, got);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    cmp_field("kind", 64'(e.kind), 64'(got.kind));
    cmp_field("address", e.address, got.address);
    cmp_field("byte_count", 64'(e.byte_count), 64'(got.byte_count));
    cmp_field("direction", 64'(e.direction), 64'(got.direction));
    cmp_field("status", 64'(e.status), 64'(got.status));
    cmp_field("finished", 64'(e.finished), 64'(got.finished));
    checked++;
    case (e.kind)
      KIND_SEGMENT: n_seg++;
      KIND_FETCH:   n_fetch++;
      default:      n_err++;
    endcase
  endfunction
endclass

module prp_list_dma_walker_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned IDLE_PAD    = 6;
  localparam int unsigned HOLD_CYCLES = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pdw_in_t            in_data;
  logic               out_valid;
  logic               out_stall;
  pdw_out_t           out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_W-1:0]   pwdata;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  prp_walk_board sb = new();

  int unsigned cycle_count = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned stall_left  = 0;
  int unsigned free_left   = 0;
  int unsigned settings    = 1;
  int unsigned rcv_pick;
  bit          stall_next;

  prp_list_dma_walker #(.PAGE_BYTES(WALK_PAGE)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_req != hold_seen) begin
      hold_seen  = hold_req;
      stall_left = HOLD_CYCLES;
      free_left  = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      stall_next = 1'b0;
    end else begin
      rcv_pick = $urandom_range(99);
      if (rcv_pick < 40) begin
        free_left  = $urandom_range(30);
        stall_next = 1'b0;
      end else begin
        stall_next = 1'b1;
        if (rcv_pick < 85) stall_left = $urandom_range(2);
        else if (rcv_pick < 97) stall_left = $urandom_range(19, 3);
        else stall_left = $urandom_range(79, 29);
      end
    end
    out_stall <= stall_next;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] page_align(logic [63:0] x);
    return x & ~64'(WALK_PAGE - 1);
  endfunction

  function automatic pdw_in_t mk_start(logic [63:0] p1, logic [63:0] p2, int unsigned len,
                                       logic dir);
    pdw_in_t it;
    it.mode           = 1'b0;
    it.first_pointer  = p1;
    it.second_pointer = p2;
    it.byte_length    = len[LEN_W-1:0];
    it.to_host        = dir;
    it.list_entry     = rand64();
    return it;
  endfunction

  function automatic pdw_in_t mk_entry(logic [63:0] e);
    pdw_in_t it;
    it.mode           = 1'b1;
    it.first_pointer  = rand64();
    it.second_pointer = rand64();
    it.byte_length    = LEN_W'($urandom);
    it.to_host        = 1'($urandom_range(1));
    it.list_entry     = e;
    return it;
  endfunction

  function automatic logic [63:0] rand_entry();
    int unsigned r;
    logic [63:0] x;
    r = $urandom_range(99);
    x = rand64();
    if (r < 90) begin
      x = page_align(x);
      if (x == 0) x = 64'(WALK_PAGE);
    end else if (r < 94) begin
      x = '0;
    end else if (x[11:0] == 0) begin
      x[0] = 1'b1;
    end
    return x;
  endfunction

  function automatic int unsigned rand_len(int unsigned maxx);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 4) len = 0;
    else if (r < 8) len = maxx + 1 + $urandom_range(100);
    else if (r < 40) len = $urandom_range(WALK_PAGE, 1);
    else if (r < 70) len = $urandom_range(2 * WALK_PAGE, WALK_PAGE + 1);
    else if (r < 99) len = $urandom_range(6 * WALK_PAGE, 2 * WALK_PAGE + 1);
    else len = $urandom_range(1048576, 1);
    if (len > 1048576) len = 1048576;
    return len;
  endfunction

  function automatic pdw_in_t rand_start();
    int unsigned r;
    logic [63:0] p1;
    logic [63:0] p2;
    r = $urandom_range(99);
    if (r < 5) p1 = '0;
    else if (r < 8) p1 = '1;
    else if (r < 35) p1 = page_align(rand64());
    else p1 = rand64();
    r = $urandom_range(99);
    if (r < 5) p2 = '0;
    else if (r < 15) p2 = rand64() | 64'h1;
    else if (r < 18) p2 = 64'hFFFF_FFFF_FFFF_F000;
    else p2 = page_align(rand64());
    return mk_start(p1, p2, rand_len(sb.max_xfer), 1'($urandom_range(1)));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  task automatic offer(input pdw_in_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input int unsigned value);
    logic [APB_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(sel, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.check_reg(sel, rd);
  endtask

  task automatic set_phase(input int unsigned xfer, input int unsigned list);
    drain();
    cfg_write(REG_MAX_XFER, xfer);
    cfg_write(REG_MAX_LIST, list);
    settings++;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned done_cnt;
    int unsigned r;
    pdw_in_t it;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      r = $urandom_range(99);
      if (sb.awaiting && r < 96) begin
        it = mk_entry(rand_entry());
        done_cnt++;
      end else if (!sb.awaiting && r < 8) begin
        it = mk_entry(rand_entry());
      end else begin
        it = rand_start();
        done_cnt++;
      end
      offer(it);
      if ($urandom_range(149) == 0) drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(mk_start(64'h1000, 64'h2000, 0, 1'b0));
    offer(mk_start(64'h0, 64'h2000, 100, 1'b1));
    offer(mk_start(64'h1000, 64'h2000, 32769, 1'b0));
    offer(mk_start(64'h1000, 64'h0, 5000, 1'b1));
    offer(mk_start(64'h1000, 64'h0, 4096, 1'b0));
    offer(mk_start('1, 64'h2000, 1, 1'b1));
    offer(mk_start(64'hABCD_0800, 64'h5000, 4096, 1'b0));
    offer(mk_start(64'h7000, 64'h8000, 8192, 1'b1));
    offer(mk_start(64'h7000, 64'h8010, 12288, 1'b0));
    offer(mk_entry(64'h9000));
    offer(mk_start(64'h1000, 64'hFFFF_FFFF_FFFF_F000, 12000, 1'b1));
    offer(mk_entry(64'hFFFF_FFFF_FFFF_F000));
    offer(mk_entry(64'h0010_0000));
    offer(mk_start(64'h1000, 64'h3000, 20000, 1'b1));
    offer(mk_entry(64'h0));
    offer(mk_start(64'h1000, 64'h3000, 20000, 1'b0));
    offer(mk_entry(64'h4800));
    offer(mk_start(64'h1000, 64'h3000, 20000, 1'b1));
    offer(mk_entry(64'h4000));
    offer(mk_start(64'h2000, 64'h5000, 300, 1'b0));
    offer(mk_entry(64'h6000));
    offer(mk_start(64'h1000, 64'h3000, 32768, 1'b1));

    set_phase(1048576, 2);
    offer(mk_start(64'h1000, 64'h2_0000, 16384, 1'b1));
    offer(mk_entry(64'h3_0000));
    offer(mk_entry(64'h4_0000));
    offer(mk_start(64'h10_0000, 64'h20_0000, 1048576, 1'b0));
    offer(mk_entry(64'h30_0000));
    offer(mk_entry(64'h40_0000));
    hold_req <= hold_req + 1;
    run_random(170);

    set_phase(1, 512);
    offer(mk_start(64'h1000, 64'h0, 1, 1'b0));
    offer(mk_start(64'h1000, 64'h0, 2, 1'b1));
    run_random(170);

    set_phase(1048576, 512);
    run_random(170);

    set_phase($urandom_range(1048576, 1), $urandom_range(512, 2));
    hold_req <= hold_req + 1;
    run_random(170);

    set_phase(32768, 64);
    run_random(150);

    drain();
    repeat (16) @(posedge clk);
    $display("Accepted %0d input transactions across %0d register settings; checked %0d results",
             sb.accepted, settings, sb.checked);
    $display("Results seen: %0d data segments, %0d entry fetches, %0d errors",
             sb.n_seg, sb.n_fetch, sb.n_err);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: prp_list_dma_walker.f
design/pdw_pkg.sv
design/pdw_cfg_regs.sv
design/pdw_walk_core.sv
design/pdw_result_buf.sv
design/prp_list_dma_walker.sv
dv/prp_list_dma_walker_tb.sv
